// ----- hw/rtl/vcrfri_pkg.sv -----
`default_nettype none
package vcrfri_pkg;

	localparam int NUM_REGS   = 64;
	localparam int ADDR_W     = 6;
	localparam int DATA_W     = 8;
	localparam int LINE_W     = 9;
	localparam int MODE_W     = 3;
	localparam int IN_TDATA_W = 24;
	localparam int OUT_TDATA_W = 16;

	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_READ  = 2'd1,
		KIND_TICK  = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_READ = 1'b1
	} st_t;

	localparam logic [ADDR_W-1:0] REG_CTRL1   = 6'h11;
	localparam logic [ADDR_W-1:0] REG_RASTER  = 6'h12;
	localparam logic [ADDR_W-1:0] REG_LPEN_X  = 6'h13;
	localparam logic [ADDR_W-1:0] REG_LPEN_Y  = 6'h14;
	localparam logic [ADDR_W-1:0] REG_CTRL2   = 6'h16;
	localparam logic [ADDR_W-1:0] REG_IRQ     = 6'h19;
	localparam logic [ADDR_W-1:0] REG_IRQ_EN  = 6'h1a;
	localparam logic [ADDR_W-1:0] REG_COLL_SS = 6'h1e;
	localparam logic [ADDR_W-1:0] REG_COLL_SB = 6'h1f;

	localparam logic [MODE_W-1:0] MODE_MC = 3'b001;
	localparam logic [MODE_W-1:0] MODE_BM = 3'b010;
	localparam logic [MODE_W-1:0] MODE_EC = 3'b100;

	// bits with no storage behind them: kept 0, read back as 1
	function automatic logic [DATA_W-1:0] nc_mask(input logic [ADDR_W-1:0] a);
		logic [DATA_W-1:0] m;
		m = 8'h00;
		if (a == 6'h16) begin
			m = 8'hc0;
		end else if (a == 6'h18) begin
			m = 8'h01;
		end else if (a == REG_IRQ) begin
			m = 8'h70;
		end else if (a == REG_IRQ_EN) begin
			m = 8'hf0;
		end else if (a >= 6'h20 && a <= 6'h2e) begin
			m = 8'hf0;
		end else if (a >= 6'h2f) begin
			m = 8'hff;
		end
		return m;
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/vcrfri_ram.sv -----
`default_nettype none
module vcrfri_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ----- hw/rtl/video_chip_register_file_raster_irq.sv -----
// Results: writes, raster ticks and unused kinds give their result in the cycle after
// acceptance; reads pass through the registered RAM read and then the output register.
// Throughput: one write or tick per cycle; a read blocks new items until it leaves the
// registered read port of the register RAM. Input stalls while a result waits unclaimed.
// Reset (arst_n low): registers, compare, line, mode and interrupt state clear to zero
// (unconnected bits read as 1), output empty; per-entry valid flops replace a RAM clear.
`default_nettype none
module video_chip_register_file_raster_irq (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// [5:0] address, [13:6] write_data, [22:14] raster_line, [23] zero
	input  wire logic [vcrfri_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// [1:0] kind
	input  wire logic [1:0]  s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [7:0] read_data, [8] irq, [11:9] mode_bits, [15:12] zero
	output logic [vcrfri_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import vcrfri_pkg::*;

	st_t                state_q, state_d;
	logic [NUM_REGS-1:0] valid_q;
	logic [LINE_W-1:0]  compare_q, line_q;
	logic [MODE_W-1:0]  mode_q, mode_d;
	logic [DATA_W-1:0]  latch_q, enable_q;
	logic               out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	logic [ADDR_W-1:0]  addr_s1;
	logic               valid_s1;

	kind_t              kind;
	logic [ADDR_W-1:0]  in_addr;
	logic [DATA_W-1:0]  in_wdata;
	logic [LINE_W-1:0]  in_line;
	logic               accept;

	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	logic [DATA_W-1:0]  ram_wdata;
	logic [DATA_W-1:0]  ram_rdata;
	logic [DATA_W-1:0]  mem_val;

	logic               tick_match, tick_fire;
	logic [DATA_W-1:0]  rd_val;
	logic               load_out;
	logic [DATA_W-1:0]  out_rd;
	logic               out_irq;

	assign kind     = kind_t'(s_axis_tuser);
	assign in_addr  = s_axis_tdata[5:0];
	assign in_wdata = s_axis_tdata[13:6];
	assign in_line  = s_axis_tdata[22:14];

	assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	vcrfri_ram #(
		.WIDTH(DATA_W),
		.DEPTH(NUM_REGS)
	) u_regs (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(in_addr),
		.rdata(ram_rdata)
	);

	// never-written entries read as their reset value
	assign mem_val = valid_s1 ? ram_rdata : '0;

	assign tick_match = (in_line == compare_q);
	assign tick_fire  = (latch_q[0] | tick_match) & enable_q[0];

	always_comb begin
		case (addr_s1)
			REG_CTRL1:   rd_val = {line_q[8], mem_val[6:0]};
			REG_RASTER:  rd_val = line_q[7:0];
			REG_LPEN_X,
			REG_LPEN_Y:  rd_val = '0;
			REG_IRQ:     rd_val = latch_q | nc_mask(REG_IRQ);
			REG_IRQ_EN:  rd_val = enable_q | nc_mask(REG_IRQ_EN);
			default:     rd_val = mem_val | nc_mask(addr_s1);
		endcase
	end

	always_comb begin
		state_d   = state_q;
		mode_d    = mode_q;
		ram_we    = 1'b0;
		ram_waddr = in_addr;
		ram_wdata = in_wdata & ~nc_mask(in_addr);
		load_out  = 1'b0;
		out_rd    = '0;
		out_irq   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (kind)
						KIND_WRITE: begin
							ram_we   = 1'b1;
							load_out = 1'b1;
							if (in_addr == REG_CTRL1) begin
								mode_d = (mode_q & MODE_MC)
									| (in_wdata[6] ? MODE_EC : '0)
									| (in_wdata[5] ? MODE_BM : '0);
							end else if (in_addr == REG_CTRL2) begin
								mode_d = (mode_q & ~MODE_MC) | (in_wdata[4] ? MODE_MC : '0);
							end
						end
						KIND_READ: begin
							state_d = ST_READ;
						end
						KIND_TICK: begin
							load_out = 1'b1;
							out_irq  = tick_fire;
						end
						default: begin
							load_out = 1'b1;
						end
					endcase
				end
			end
			ST_READ: begin
				load_out = 1'b1;
				out_rd   = rd_val;
				state_d  = ST_IDLE;
				// collision registers clear on read
				if (addr_s1 == REG_COLL_SS || addr_s1 == REG_COLL_SB) begin
					ram_we    = 1'b1;
					ram_waddr = addr_s1;
					ram_wdata = '0;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			compare_q   <= '0;
			line_q      <= '0;
			mode_q      <= '0;
			latch_q     <= '0;
			enable_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			mode_q <= mode_d;
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (accept && kind == KIND_WRITE) begin
				if (in_addr == REG_CTRL1) begin
					compare_q[8] <= in_wdata[7];
				end
				if (in_addr == REG_RASTER) begin
					compare_q[7:0] <= in_wdata;
				end
				if (in_addr == REG_IRQ) begin
					latch_q <= latch_q & ~in_wdata;
				end
				if (in_addr == REG_IRQ_EN) begin
					enable_q <= in_wdata & ~nc_mask(REG_IRQ_EN);
				end
			end
			if (accept && kind == KIND_TICK) begin
				line_q  <= in_line;
				latch_q <= latch_q | {tick_fire, 6'b0, tick_match};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1  <= in_addr;
			valid_s1 <= valid_q[in_addr];
		end
		if (load_out) begin
			out_data_q <= {4'b0, mode_d, out_irq, out_rd};
		end
	end

`ifndef SYNTHESIS
	a_read_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> !out_valid_q)
		else $error("read completes into an occupied output register");

	a_irq_sets_latch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q[8] |-> latch_q[7] && enable_q[0])
		else $error("irq reported without latch bit 7 and enable set");

	a_read_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |=> state_q == ST_IDLE && out_valid_q)
		else $error("read did not deliver its item");
`endif

endmodule
`default_nettype wire
